### sv/text_mode_pixel_generator_assert.svh
// ----------------------------------------------------------------------------
// Text-mode pixel generator assertion macros
// Concurrent assertion wrappers clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_PIXEL_GENERATOR_ASSERT_SVH
`define TEXT_MODE_PIXEL_GENERATOR_ASSERT_SVH

// property checked only outside reset
`define TMPG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define TMPG_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/tmpg_pkg.sv
// ----------------------------------------------------------------------------
// tmpg_pkg
// Shared types and constants of the text-mode pixel generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tmpg_pkg;

	typedef enum logic [1:0] {
		OP_TILE  = 2'd0,
		OP_GLYPH = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	localparam int FONT_DEPTH = 2048;
	localparam int FONT_AW    = 11;
	localparam int TILE_IDX_W = 11;
	localparam int PX_W       = 10;
	localparam int PY_W       = 9;

	typedef logic [11:0] colour_t;
	typedef logic [23:0] rgb_t;

	// 12-bit RGB to 8 bits per channel, red in the low byte
	function automatic rgb_t expand_colour(input colour_t c);
		rgb_t r;
		r = {c[3:0], c[3:0], c[7:4], c[7:4], c[11:8], c[11:8]};
		return r;
	endfunction

endpackage

`default_nettype wire

### sv/tmpg_ram.sv
// ----------------------------------------------------------------------------
// tmpg_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tmpg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### sv/tmpg_coord_div.sv
// ----------------------------------------------------------------------------
// tmpg_coord_div
// Divides the display coordinates by the pixel scale through a reciprocal
// multiply and holds the scaled coordinates until the next load.
// ----------------------------------------------------------------------------
`default_nettype none

module tmpg_coord_div
	import tmpg_pkg::*;
#(
	parameter int PIXEL_SCALE = 2
) (
	input  wire logic            clk,
	input  wire logic            load,
	input  wire logic [PX_W-1:0] pixel_x,
	input  wire logic [PY_W-1:0] pixel_y,
	output logic      [PX_W-1:0] sx,
	output logic      [PY_W-1:0] sy
);

	// exact for inputs below 2^10 since x * error < 2^RSH
	localparam int RSH   = 20;
	localparam int RECIP = (1 << RSH) / PIXEL_SCALE + 1;
	localparam int PW    = RSH + PX_W + 1;

	logic [PW-1:0] prod_x;
	logic [PW-1:0] prod_y;
	logic [PX_W-1:0] sx_q;
	logic [PY_W-1:0] sy_q;

	assign prod_x = PW'(pixel_x) * PW'(RECIP);
	assign prod_y = PW'(pixel_y) * PW'(RECIP);

	always_ff @(posedge clk) begin
		if (load) begin
			sx_q <= prod_x[RSH+PX_W-1:RSH];
			sy_q <= prod_y[RSH+PY_W-1:RSH];
		end
	end

	assign sx = sx_q;
	assign sy = sy_q;

endmodule

`default_nettype wire

### sv/text_mode_pixel_generator.sv
// ----------------------------------------------------------------------------
// text_mode_pixel_generator
// Text-mode pixel generator: tile store and font store in block RAM, pixel
// queries return the 24-bit RGB colour of one display pixel.
// ----------------------------------------------------------------------------
// After reset the block clears both stores, one entry a cycle, over
// max(TILE_DEPTH, 2048) entries with s_tready low. A tile or glyph write then
// goes to its store in the cycle it is accepted. A pixel query passes four
// register stages: scale divide (loaded at acceptance), tile RAM read, font
// RAM read, colour select. The next item is accepted the cycle after the
// result is loaded, so no new item is taken while a query is in flight; the
// query rate is bounded by the two dependent RAM reads. A waiting result does
// not block the following writes, but a query that reaches colour select
// waits there, with s_tready low, until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module text_mode_pixel_generator
	import tmpg_pkg::*;
#(
	parameter int PIXEL_SCALE  = 2,
	parameter int TEXT_COLUMNS = 40,
	parameter int TILE_DEPTH   = 2048
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// pixel_x[9:0] pixel_y[18:10] tile_index[29:19] tile_word[61:30]
	// glyph_code[69:62] glyph_row[72:70] glyph_bits[80:73] zero[87:81]
	input  wire logic [87:0] s_tdata,
	// operation[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// red[7:0] green[15:8] blue[23:16]
	output logic      [23:0] m_tdata
);

	localparam int TILE_AW = $clog2(TILE_DEPTH);
	localparam int CELL_W  = $clog2(127 + 63 * TEXT_COLUMNS + 1);
	localparam int CW1     = (CELL_W > TILE_AW + 1) ? CELL_W : TILE_AW + 1;
	localparam int CMP_W   = (CW1 > TILE_IDX_W) ? CW1 : TILE_IDX_W;
	localparam int CLR_N   = (TILE_DEPTH > FONT_DEPTH) ? TILE_DEPTH : FONT_DEPTH;
	localparam int CLR_W   = $clog2(CLR_N);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADDR,
		ST_TILE,
		ST_FONT
	} state_t;

	state_t state_q;
	logic [CLR_W-1:0] clr_q;
	logic             oor_q;
	logic [31:0]      word_q;
	logic             out_valid_q;
	rgb_t             out_q;

	logic [PX_W-1:0]       in_px;
	logic [PY_W-1:0]       in_py;
	logic [TILE_IDX_W-1:0] in_tidx;
	logic [31:0]           in_tword;
	logic [7:0]            in_gcode;
	logic [2:0]            in_grow;
	logic [7:0]            in_gbits;

	logic in_fire;
	logic query_load;

	logic [PX_W-1:0] sx;
	logic [PY_W-1:0] sy;

	logic               tile_we;
	logic [TILE_AW-1:0] tile_waddr;
	logic [31:0]        tile_wdata;
	logic [TILE_AW-1:0] tile_raddr;
	logic [31:0]        tile_rdata;

	logic               font_we;
	logic [FONT_AW-1:0] font_waddr;
	logic [7:0]         font_wdata;
	logic [FONT_AW-1:0] font_raddr;
	logic [7:0]         font_rdata;

	logic [CELL_W-1:0] cell_idx;
	logic [CMP_W-1:0]  cell_ext;
	logic [CMP_W-1:0]  tidx_ext;
	logic              cell_in_range;
	logic [31:0]       word;
	logic              glyph_bit;
	colour_t           colour;
	logic              out_free;

	assign in_px    = s_tdata[9:0];
	assign in_py    = s_tdata[18:10];
	assign in_tidx  = s_tdata[29:19];
	assign in_tword = s_tdata[61:30];
	assign in_gcode = s_tdata[69:62];
	assign in_grow  = s_tdata[72:70];
	assign in_gbits = s_tdata[80:73];

	assign s_tready   = (state_q == ST_IDLE);
	assign in_fire    = s_tvalid && s_tready;
	assign query_load = in_fire && (op_t'(s_tuser) == OP_QUERY);
	assign out_free   = !out_valid_q || m_tready;

	tmpg_coord_div #(
		.PIXEL_SCALE(PIXEL_SCALE)
	) u_div (
		.clk    (clk),
		.load   (query_load),
		.pixel_x(in_px),
		.pixel_y(in_py),
		.sx     (sx),
		.sy     (sy)
	);

	assign cell_idx = CELL_W'(sx[PX_W-1:3]) + CELL_W'(sy[PY_W-1:3]) * CELL_W'(TEXT_COLUMNS);
	assign cell_ext      = CMP_W'(cell_idx);
	assign cell_in_range = cell_ext < CMP_W'(TILE_DEPTH);
	assign tidx_ext      = CMP_W'(in_tidx);
	assign word          = oor_q ? 32'd0 : tile_rdata;
	assign glyph_bit     = font_rdata[3'd7 - sx[2:0]];
	assign colour        = glyph_bit ? word_q[31:20] : word_q[19:8];

	always_comb begin
		tile_we    = 1'b0;
		tile_waddr = tidx_ext[TILE_AW-1:0];
		tile_wdata = in_tword;
		font_we    = 1'b0;
		font_waddr = {in_gcode, in_grow};
		font_wdata = in_gbits;
		case (state_q)
			ST_CLEAR: begin
				tile_we    = {1'b0, clr_q} < (CLR_W + 1)'(TILE_DEPTH);
				tile_waddr = clr_q[TILE_AW-1:0];
				tile_wdata = 32'd0;
				font_we    = {1'b0, clr_q} < (CLR_W + 1)'(FONT_DEPTH);
				font_waddr = clr_q[FONT_AW-1:0];
				font_wdata = 8'd0;
			end
			ST_IDLE: begin
				tile_we = in_fire && (op_t'(s_tuser) == OP_TILE)
					&& (tidx_ext < CMP_W'(TILE_DEPTH));
				font_we = in_fire && (op_t'(s_tuser) == OP_GLYPH);
			end
			default: begin
			end
		endcase
	end

	assign tile_raddr = cell_ext[TILE_AW-1:0];
	assign font_raddr = {word[7:0], sy[2:0]};

	tmpg_ram #(
		.WIDTH(32),
		.DEPTH(TILE_DEPTH)
	) u_tile_ram (
		.clk  (clk),
		.we   (tile_we),
		.waddr(tile_waddr),
		.wdata(tile_wdata),
		.raddr(tile_raddr),
		.rdata(tile_rdata)
	);

	tmpg_ram #(
		.WIDTH(8),
		.DEPTH(FONT_DEPTH)
	) u_font_ram (
		.clk  (clk),
		.we   (font_we),
		.waddr(font_waddr),
		.wdata(font_wdata),
		.raddr(font_raddr),
		.rdata(font_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			oor_q       <= 1'b0;
			word_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && m_tready && (state_q != ST_FONT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_W'(CLR_N - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (query_load) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					oor_q   <= !cell_in_range;
					state_q <= ST_TILE;
				end
				ST_TILE: begin
					word_q  <= word;
					state_q <= ST_FONT;
				end
				ST_FONT: begin
					if (out_free) begin
						out_q       <= expand_colour(colour);
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

`default_nettype wire

### sv/tmpg_checker.sv
// ----------------------------------------------------------------------------
// tmpg_checker
// Port-level assertions of the text-mode pixel generator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_mode_pixel_generator_assert.svh"

module tmpg_checker
	import tmpg_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [1:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata
);

	logic query_fire;

	assign query_fire = s_tvalid && s_tready && (s_tuser == OP_QUERY);

	`TMPG_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
	`TMPG_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")
	`TMPG_ASSERT(a_nibble_gain, m_tvalid |-> (m_tdata[3:0] == m_tdata[7:4]) && (m_tdata[11:8] == m_tdata[15:12]) && (m_tdata[19:16] == m_tdata[23:20]), "channel is not a nibble times 17")
	`TMPG_ASSERT(a_query_latency, $rose(m_tvalid) |-> $past($past($past($past(query_fire)))), "result without a query four cycles before")

endmodule

bind text_mode_pixel_generator tmpg_checker u_tmpg_checker (.*);

`default_nettype wire

### tb/tb_text_mode_pixel_generator.sv
// ----------------------------------------------------------------------------
// tb_text_mode_pixel_generator
// Self-checking bench for the text-mode pixel generator. A short table of
// directed transactions is followed by randomized tile/glyph fills and
// pixel queries. Every query is checked channel by channel against a typed
// colour or an in-bench predictor with copies of the tile and font stores.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_text_mode_pixel_generator;
	import tmpg_pkg::*;

	localparam int SCALE      = 2;
	localparam int COLUMNS    = 40;
	localparam int TILES      = 2048;
	localparam int RAND_ITEMS = 600;
	localparam int IDLE_LIMIT = 10000;
	localparam int HOLD_LEN   = 250;
	localparam int DRAIN      = 16;
	localparam int N_DIRECTED = 22;

	localparam logic [1:0] OP_NONE = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [9:0]  px;
		logic [8:0]  py;
		logic [10:0] tidx;
		logic [31:0] tword;
		logic [7:0]  gcode;
		logic [2:0]  grow;
		logic [7:0]  gbits;
		logic        typed;
		logic [23:0] rgb;
	} stim_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	logic [31:0] tile_copy [TILES];
	logic [7:0]  font_copy [FONT_DEPTH];
	pixel_t      pixel_queue [$];

	int  errors = 0;
	int  stall_cycles = 0;
	bit  want_hold = 1'b0;
	bit  holding = 1'b0;
	bit  hold_done = 1'b0;

	text_mode_pixel_generator #(
		.PIXEL_SCALE (SCALE),
		.TEXT_COLUMNS(COLUMNS),
		.TILE_DEPTH  (TILES)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// directed transactions; rgb is only meaningful where typed is set
	stim_t directed_rows [N_DIRECTED] = '{
		'{OP_QUERY, 10'd0,    9'd0,   11'd0,    32'h0,        8'h00, 3'd0, 8'h00, 1'b1, 24'h0},
		'{OP_QUERY, 10'd1023, 9'd511, 11'd0,    32'h0,        8'h00, 3'd0, 8'h00, 1'b1, 24'h0},
		'{OP_GLYPH, 10'd0,    9'd0,   11'd0,    32'h0,        8'h41, 3'd0, 8'h80, 1'b0, 24'h0},
		'{OP_GLYPH, 10'd0,    9'd0,   11'd0,    32'h0,        8'h41, 3'd7, 8'h01, 1'b0, 24'h0},
		'{OP_GLYPH, 10'd0,    9'd0,   11'd0,    32'h0,        8'hff, 3'd7, 8'hff, 1'b0, 24'h0},
		'{OP_GLYPH, 10'd0,    9'd0,   11'd0,    32'h0,        8'h00, 3'd3, 8'haa, 1'b0, 24'h0},
		'{OP_TILE,  10'd0,    9'd0,   11'd0,    32'hfff00041, 8'h00, 3'd0, 8'h00, 1'b0, 24'h0},
		'{OP_QUERY, 10'd0,    9'd0,   11'd0,    32'h0,        8'h00, 3'd0, 8'h00, 1'b1, 24'hffffff},
		'{OP_QUERY, 10'd2,    9'd0,   11'd0,    32'h0,        8'h00, 3'd0, 8'h00, 1'b1, 24'h0},
		'{OP_QUERY, 10'd15,   9'd15,  11'd0,    32'h0,        8'h00, 3'd0, 8'h00, 1'b1, 24'hffffff},
		'{OP_TILE,  10'd0,    9'd0,   11'd2047, 32'hffffffff, 8'h00, 3'd0, 8'h00, 1'b0, 24'h0},
		'{OP_TILE,  10'd0,    9'd0,   11'd1,    32'h12345600, 8'h00, 3'd0, 8'h00, 1'b0, 24'h0},
		'{OP_QUERY, 10'd16,   9'd6,   11'd0,    32'h0,        8'h00, 3'd0, 8'h00, 1'b0, 24'h0},
		'{OP_QUERY, 10'd18,   9'd6,   11'd0,    32'h0,        8'h00, 3'd0, 8'h00, 1'b0, 24'h0},
		'{OP_TILE,  10'd0,    9'd0,   11'd40,   32'habc0deff, 8'h00, 3'd0, 8'h00, 1'b0, 24'h0},
		// column past the text width wraps into the next text row
		'{OP_QUERY, 10'd640,  9'd14,  11'd0,    32'h0,        8'h00, 3'd0, 8'h00, 1'b0, 24'h0},
		'{OP_QUERY, 10'd1023, 9'd511, 11'd0,    32'h0,        8'h00, 3'd0, 8'h00, 1'b1, 24'h0},
		'{OP_NONE,  10'd1023, 9'd511, 11'd2047, 32'hffffffff, 8'hff, 3'd7, 8'hff, 1'b0, 24'h0},
		'{OP_QUERY, 10'd0,    9'd0,   11'd2047, 32'hffffffff, 8'hff, 3'd7, 8'hff, 1'b0, 24'h0},
		'{OP_TILE,  10'd1023, 9'd511, 11'd0,    32'h0,        8'hff, 3'd7, 8'hff, 1'b0, 24'h0},
		'{OP_GLYPH, 10'd1023, 9'd511, 11'd2047, 32'hffffffff, 8'h41, 3'd0, 8'h00, 1'b0, 24'h0},
		'{OP_QUERY, 10'd0,    9'd0,   11'd0,    32'h0,        8'h00, 3'd0, 8'h00, 1'b1, 24'h0}
	};

	function automatic logic [7:0] widen(input logic [3:0] nib);
		return 8'(int'(nib) * 17);
	endfunction

	function automatic pixel_t render_pixel(input logic [9:0] px, input logic [8:0] py);
		int          sx;
		int          sy;
		int          cell_idx;
		logic [31:0] word;
		logic [7:0]  bits;
		logic [11:0] colour;
		pixel_t      p;
		sx = int'(px) / SCALE;
		sy = int'(py) / SCALE;
		cell_idx = (sx >> 3) + (sy >> 3) * COLUMNS;
		word = (cell_idx < TILES) ? tile_copy[cell_idx] : 32'h0;
		bits = font_copy[{word[7:0], 3'(sy)}];
		colour = bits[7 - (sx & 7)] ? word[31:20] : word[19:8];
		p.red = widen(colour[11:8]);
		p.green = widen(colour[7:4]);
		p.blue = widen(colour[3:0]);
		return p;
	endfunction

	task automatic apply_transaction(input stim_t it);
		if (it.op == OP_TILE) begin
			if (int'(it.tidx) < TILES)
				tile_copy[it.tidx] = it.tword;
		end else if (it.op == OP_GLYPH) begin
			font_copy[{it.gcode, it.grow}] = it.gbits;
		end else if (it.op == OP_QUERY) begin
			if (it.typed)
				pixel_queue.push_back(pixel_t'(it.rgb));
			else
				pixel_queue.push_back(render_pixel(it.px, it.py));
		end
	endtask

	task automatic offer(input stim_t it);
		s_tuser <= it.op;
		s_tdata <= {7'b0, it.gbits, it.grow, it.gcode, it.tword, it.tidx, it.py, it.px};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		apply_transaction(it);
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic stim_t random_item();
		stim_t it;
		int    r;
		int    cx;
		int    cy;
		it = '0;
		it.px = 10'($urandom);
		it.py = 9'($urandom);
		it.tidx = 11'($urandom);
		it.tword = $urandom;
		it.gcode = 8'($urandom);
		it.grow = 3'($urandom);
		it.gbits = 8'($urandom);
		r = $urandom_range(99);
		if (r < 22) begin
			it.op = OP_TILE;
			if ($urandom_range(99) < 70) begin
				cx = $urandom_range(7);
				cy = $urandom_range(3);
				it.tidx = 11'(cx + cy * COLUMNS);
			end
			if ($urandom_range(99) < 80)
				it.tword[7:0] = 8'($urandom_range(7));
		end else if (r < 42) begin
			it.op = OP_GLYPH;
			if ($urandom_range(99) < 80)
				it.gcode = 8'($urandom_range(7));
		end else if (r < 95) begin
			it.op = OP_QUERY;
			if ($urandom_range(99) < 75) begin
				it.px = 10'($urandom_range(8 * 8 * SCALE - 1));
				it.py = 9'($urandom_range(4 * 8 * SCALE - 1));
			end
		end else begin
			it.op = OP_NONE;
		end
		return it;
	endfunction

	initial begin
		stim_t it;
		int    gap;
		int    burst_left;
		int    useful;
		burst_left = 0;
		useful = 0;
		for (int i = 0; i < TILES; i++)
			tile_copy[i] = '0;
		for (int i = 0; i < FONT_DEPTH; i++)
			font_copy[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			offer(directed_rows[i]);
			gap = gap_len();
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end

		while (useful < RAND_ITEMS) begin
			it = random_item();
			offer(it);
			if (it.op != OP_NONE)
				useful++;
			if (useful == 150)
				want_hold = 1'b1;
			if (burst_left > 0)
				burst_left--;
			else if ($urandom_range(99) < 4)
				burst_left = $urandom_range(40, 15);
			gap = (holding || burst_left > 0) ? 0 : gap_len();
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;

		while (pixel_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// result side: random run/stall pattern plus one long hold-off
	initial begin
		int run;
		int gap;
		@(posedge arst_n);
		forever begin
			if (want_hold && !hold_done) begin
				holding = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				holding = 1'b0;
				hold_done = 1'b1;
			end
			m_tready <= 1'b1;
			run = ($urandom_range(99) < 10) ? $urandom_range(120, 40) : $urandom_range(20, 1);
			repeat (run) @(posedge clk);
			gap = gap_len();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	task automatic check_channel(input string name, input logic [7:0] exp_v,
		input logic [7:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		pixel_t got;
		pixel_t exp_p;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pixel_queue.size() == 0) begin
				$display("%0t: unexpected result transaction, expected none actual %h",
					$time, got);
				errors++;
			end else begin
				exp_p = pixel_queue.pop_front();
				check_channel("red", exp_p.red, got.red);
				check_channel("green", exp_p.green, got.green);
				check_channel("blue", exp_p.blue, got.blue);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= IDLE_LIMIT) begin
				$display("%0t: watchdog expired, %0d results pending",
					$time, pixel_queue.size());
				$display("TB_ERROR");
				$finish;
			end
		end
	end

endmodule
